[rtl/skeleton_limb_pose_classifier_macros.svh]
// ----------------------------------------------------------------------------
// skeleton limb pose classifier assertion macros
// Concurrent assertion helpers used by the classifier top level; they compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SKELETON_LIMB_POSE_CLASSIFIER_MACROS_SVH
`define SKELETON_LIMB_POSE_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// implication that must hold at every clock edge outside reset
`define SLPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen at a clock edge outside reset
`define SLPC_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define SLPC_ASSERT(lbl, clk, rst, prop, msg)
`define SLPC_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

[rtl/slpc_pkg.sv]
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared types and constants of the skeleton limb pose classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package slpc_pkg;

   localparam int NUM_JOINTS          = 15;
   localparam int JOINT_IDX_W         = 4;
   localparam int CONF_W              = 8;
   localparam int POSE_W              = 3;
   localparam int COORD_WIDTH_DEFAULT = 16;

   localparam logic [CONF_W-1:0] CONF_THRESHOLD_RESET = 8'd128;

   // skeleton joint numbering
   localparam int J_HEAD   = 0;
   localparam int J_NECK   = 1;
   localparam int J_TORSO  = 2;
   localparam int J_LSHLD  = 3;
   localparam int J_LHAND  = 5;
   localparam int J_RSHLD  = 6;
   localparam int J_RHAND  = 8;
   localparam int J_LHIP   = 9;
   localparam int J_LFOOT  = 11;
   localparam int J_RHIP   = 12;
   localparam int J_RFOOT  = 14;

   typedef enum logic [POSE_W-1:0] {
      POSE_NONE  = 3'd0,
      POSE_UP    = 3'd1,
      POSE_SIDE  = 3'd2,
      POSE_FRONT = 3'd3,
      POSE_DOWN  = 3'd4
   } pose_type;

   typedef struct packed {
      pose_type rt_hand;
      pose_type lt_hand;
      pose_type lt_foot;
      pose_type rt_foot;
   } pose_set_type;

   localparam pose_set_type POSE_SET_RESET = '{
      rt_hand: POSE_NONE,
      lt_hand: POSE_NONE,
      lt_foot: POSE_NONE,
      rt_foot: POSE_NONE
   };

endpackage

`default_nettype wire

[rtl/slpc_joint_store.sv]
// ----------------------------------------------------------------------------
// slpc_joint_store
// Register file holding position and confidence of every skeleton joint.
// ----------------------------------------------------------------------------
`default_nettype none

module slpc_joint_store
   import slpc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [JOINT_IDX_W-1:0]        wr_index,
   input  wire logic signed [COORD_WIDTH-1:0] wr_x,
   input  wire logic signed [COORD_WIDTH-1:0] wr_y,
   input  wire logic signed [COORD_WIDTH-1:0] wr_z,
   input  wire logic [CONF_W-1:0]             wr_conf,
   output logic signed [COORD_WIDTH-1:0]      rd_x    [NUM_JOINTS],
   output logic signed [COORD_WIDTH-1:0]      rd_y    [NUM_JOINTS],
   output logic signed [COORD_WIDTH-1:0]      rd_z    [NUM_JOINTS],
   output logic [CONF_W-1:0]                  rd_conf [NUM_JOINTS]
);

   logic signed [COORD_WIDTH-1:0] x_ff    [NUM_JOINTS];
   logic signed [COORD_WIDTH-1:0] y_ff    [NUM_JOINTS];
   logic signed [COORD_WIDTH-1:0] z_ff    [NUM_JOINTS];
   logic [CONF_W-1:0]             conf_ff [NUM_JOINTS];

   // payload only, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_ff[wr_index]    <= wr_x;
         y_ff[wr_index]    <= wr_y;
         z_ff[wr_index]    <= wr_z;
         conf_ff[wr_index] <= wr_conf;
      end
   end

   assign rd_x    = x_ff;
   assign rd_y    = y_ff;
   assign rd_z    = z_ff;
   assign rd_conf = conf_ff;

endmodule

`default_nettype wire

[rtl/slpc_classifier.sv]
// ----------------------------------------------------------------------------
// slpc_classifier
// Single-pass limb classification from the stored joints: picks the next
// pose code of both hands and both feet.
// ----------------------------------------------------------------------------
`default_nettype none

module slpc_classifier
   import slpc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic signed [COORD_WIDTH-1:0] pos_x   [NUM_JOINTS],
   input  wire logic signed [COORD_WIDTH-1:0] pos_y   [NUM_JOINTS],
   input  wire logic signed [COORD_WIDTH-1:0] pos_z   [NUM_JOINTS],
   input  wire logic [CONF_W-1:0]             conf    [NUM_JOINTS],
   input  wire logic [CONF_W-1:0]             threshold,
   input  wire pose_set_type                  poses_cur,
   output pose_set_type                       poses_next
);

   // room for 5x a coordinate plus a full-range difference
   localparam int EW = COORD_WIDTH + 4;

   function automatic logic signed [EW-1:0] ext(input logic signed [COORD_WIDTH-1:0] v);
      return EW'(v);
   endfunction

   function automatic logic signed [EW-1:0] absd(input logic signed [COORD_WIDTH-1:0] a,
                                                 input logic signed [COORD_WIDTH-1:0] b);
      logic signed [EW-1:0] d;
      d = EW'(a) - EW'(b);
      return (d < 0) ? -d : d;
   endfunction

   logic [NUM_JOINTS-1:0] ok;

   always_comb begin
      for (int j = 0; j < NUM_JOINTS; j++) begin
         ok[j] = conf[j] > threshold;
      end
   end

   logic signed [EW-1:0] head_y, head_z, torso_y, torso_z;
   logic signed [EW-1:0] d_head_neck_y, d_neck_torso_y;

   assign head_y         = ext(pos_y[J_HEAD]);
   assign head_z         = ext(pos_z[J_HEAD]);
   assign torso_y        = ext(pos_y[J_TORSO]);
   assign torso_z        = ext(pos_z[J_TORSO]);
   assign d_head_neck_y  = absd(pos_y[J_HEAD], pos_y[J_NECK]);
   assign d_neck_torso_y = absd(pos_y[J_NECK], pos_y[J_TORSO]);

   pose_type hand_pose [2];

   for (genvar g = 0; g < 2; g++) begin : g_hand
      localparam int HJ = (g == 0) ? J_RHAND : J_LHAND;
      localparam int SJ = (g == 0) ? J_RSHLD : J_LSHLD;

      logic signed [EW-1:0] hy, hz, d_hand_sh, d_sh_head;
      logic                 up, side, front, down;
      pose_type             cur;

      assign hy        = ext(pos_y[HJ]);
      assign hz        = ext(pos_z[HJ]);
      assign d_hand_sh = absd(pos_x[HJ], pos_x[SJ]);
      assign d_sh_head = absd(pos_x[SJ], pos_x[J_HEAD]);
      assign cur       = (g == 0) ? poses_cur.rt_hand : poses_cur.lt_hand;

      // 0.2 and 1.5 factors folded into integer scaling of both sides
      assign up    = ((hy <<< 2) + hy) > ((head_y <<< 2) + head_y + d_head_neck_y);
      assign side  = (d_hand_sh <<< 1) > ((d_sh_head <<< 1) + d_sh_head);
      assign front = (hz <<< 1) < ((head_z <<< 1) - ((d_neck_torso_y <<< 1) + d_neck_torso_y));
      assign down  = hy < torso_y;

      always_comb begin
         hand_pose[g] = cur;
         priority if (up) begin
            if (ok[HJ] && ok[J_HEAD]) hand_pose[g] = POSE_UP;
         end else if (side) begin
            if (ok[HJ] && ok[SJ]) hand_pose[g] = POSE_SIDE;
         end else if (front) begin
            if (ok[HJ] && ok[J_HEAD] && ok[J_TORSO] && ok[J_NECK]) hand_pose[g] = POSE_FRONT;
         end else if (down) begin
            if (ok[HJ] && ok[J_TORSO]) hand_pose[g] = POSE_DOWN;
         end else begin
            hand_pose[g] = cur;
         end
      end
   end

   // feet
   logic signed [EW-1:0] lw, rw, lf_x, lf_z, lhip_x, rf_x, rf_z, rhip_x;
   logic                 l_side, l_front, r_side, r_front;
   pose_type             lfoot_pose, rfoot_pose;

   assign lw     = absd(pos_x[J_LHIP], pos_x[J_TORSO]);
   assign rw     = absd(pos_x[J_RHIP], pos_x[J_TORSO]);
   assign lf_x   = ext(pos_x[J_LFOOT]);
   assign lf_z   = ext(pos_z[J_LFOOT]);
   assign lhip_x = ext(pos_x[J_LHIP]);
   assign rf_x   = ext(pos_x[J_RFOOT]);
   assign rf_z   = ext(pos_z[J_RFOOT]);
   assign rhip_x = ext(pos_x[J_RHIP]);

   assign l_side  = (lf_x <<< 1) < ((lhip_x <<< 1) - ((lw <<< 1) + lw));
   assign l_front = lf_z < (torso_z - lw);
   assign r_side  = (rf_x <<< 1) > ((rhip_x <<< 1) + ((rw <<< 1) + rw));
   assign r_front = rf_z < (torso_z - rw);

   always_comb begin
      lfoot_pose = poses_cur.lt_foot;
      priority if (l_side) begin
         if (ok[J_LFOOT] && ok[J_LHIP] && ok[J_TORSO]) lfoot_pose = POSE_SIDE;
      end else if (l_front) begin
         if (ok[J_LFOOT] && ok[J_LHIP] && ok[J_TORSO]) lfoot_pose = POSE_FRONT;
      end else begin
         if (ok[J_LFOOT] && ok[J_LHIP] && ok[J_TORSO] && ok[J_RFOOT]) lfoot_pose = POSE_DOWN;
      end
   end

   // front check of the right foot looks at the left hip confidence
   always_comb begin
      rfoot_pose = poses_cur.rt_foot;
      priority if (r_side) begin
         if (ok[J_RFOOT] && ok[J_RHIP] && ok[J_TORSO]) rfoot_pose = POSE_SIDE;
      end else if (r_front) begin
         if (ok[J_RFOOT] && ok[J_LHIP] && ok[J_TORSO]) rfoot_pose = POSE_FRONT;
      end else begin
         if (ok[J_RFOOT] && ok[J_RHIP] && ok[J_TORSO]) rfoot_pose = POSE_DOWN;
      end
   end

   assign poses_next = '{
      rt_hand: hand_pose[0],
      lt_hand: hand_pose[1],
      lt_foot: lfoot_pose,
      rt_foot: rfoot_pose
   };

endmodule

`default_nettype wire

[rtl/skeleton_limb_pose_classifier.sv]
// ----------------------------------------------------------------------------
// skeleton_limb_pose_classifier
// Stores tracked skeleton joints and classifies the pose of both hands and
// both feet at the end of each frame.
// ----------------------------------------------------------------------------
// One joint request is taken every clock cycle while req_stall is low and
// written straight into the joint register file. A request with last_joint
// set marks a classification pending; once the response register is free,
// the classification reads the whole register file in one combinational
// pass and loads the four pose codes and the valid flag into the response
// register. Requests keep flowing while a response waits; req_stall rises only
// when a classification is pending and the response register is still held
// by rsp_stall. A pose code changes only when its test passes with every
// joint confidence involved strictly above the threshold; otherwise the
// previous code is repeated. Reading a joint that was never written since
// reset gives undefined poses.
`default_nettype none

`include "skeleton_limb_pose_classifier_macros.svh"

module skeleton_limb_pose_classifier
   import slpc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // joint requests
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [JOINT_IDX_W-1:0]        req_joint_index,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  wire logic [CONF_W-1:0]             req_confidence,
   input  wire logic                          req_last_joint,
   // pose responses
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [POSE_W-1:0]                  rsp_right_hand_pose,
   output logic [POSE_W-1:0]                  rsp_left_hand_pose,
   output logic [POSE_W-1:0]                  rsp_left_foot_pose,
   output logic [POSE_W-1:0]                  rsp_right_foot_pose,
   // threshold register
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CONF_W-1:0]             csr_conf_threshold
);

   logic                accept, out_free, fire;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CONF_W-1:0]   thr_ff, thr_in;
   pose_set_type        pose_ff, pose_in, pose_next;

   logic signed [COORD_WIDTH-1:0] st_x    [NUM_JOINTS];
   logic signed [COORD_WIDTH-1:0] st_y    [NUM_JOINTS];
   logic signed [COORD_WIDTH-1:0] st_z    [NUM_JOINTS];
   logic [CONF_W-1:0]             st_conf [NUM_JOINTS];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign fire      = pend_ff && out_free;
   assign csr_ready = 1'b1;

   slpc_joint_store #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (accept && (req_joint_index < JOINT_IDX_W'(NUM_JOINTS))),
      .wr_index (req_joint_index),
      .wr_x     (req_pos_x),
      .wr_y     (req_pos_y),
      .wr_z     (req_pos_z),
      .wr_conf  (req_confidence),
      .rd_x     (st_x),
      .rd_y     (st_y),
      .rd_z     (st_z),
      .rd_conf  (st_conf)
   );

   slpc_classifier #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_classifier (
      .pos_x      (st_x),
      .pos_y      (st_y),
      .pos_z      (st_z),
      .conf       (st_conf),
      .threshold  (thr_ff),
      .poses_cur  (pose_ff),
      .poses_next (pose_next)
   );

   always_comb begin
      pend_in      = accept ? req_last_joint : (pend_ff && !out_free);
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
      pose_in      = fire ? pose_next : pose_ff;
      thr_in       = csr_valid ? csr_conf_threshold : thr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pose_ff      <= POSE_SET_RESET;
         thr_ff       <= CONF_THRESHOLD_RESET;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         pose_ff      <= pose_in;
         thr_ff       <= thr_in;
      end
   end

   // the pose register doubles as the response register
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_right_hand_pose = pose_ff.rt_hand;
   assign rsp_left_hand_pose  = pose_ff.lt_hand;
   assign rsp_left_foot_pose  = pose_ff.lt_foot;
   assign rsp_right_foot_pose = pose_ff.rt_foot;

   `SLPC_ASSERT(a_rsp_from_pending, clock, reset, (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(pend_ff), "response raised without a pending classification")
   `SLPC_ASSERT(a_pose_change_on_fire, clock, reset, (!$past(reset) && !$stable(pose_ff)) |-> $past(pend_ff && out_free), "pose codes changed outside a classification")
   `SLPC_NEVER(a_stall_only_pending, clock, reset, req_stall && !pend_ff, "request stalled with no classification pending")

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// skeleton limb pose classifier testbench
// Streams skeleton frames into the classifier, predicts the four limb pose
// codes from its own copy of the joint store and threshold, and checks every
// pose response in order. Runs several threshold settings and idle patterns,
// including a long response hold-off that backs up the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import slpc_pkg::*;
();

   localparam int COORD_W     = COORD_WIDTH_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct {
      logic [JOINT_IDX_W-1:0] joint_index;
      coord_type              pos_x;
      coord_type              pos_y;
      coord_type              pos_z;
      logic [CONF_W-1:0]      confidence;
      logic                   last_joint;
   } joint_req_type;

   typedef struct {
      longint x;
      longint y;
      longint z;
      int     conf;
   } joint_entry_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [JOINT_IDX_W-1:0] req_joint_index = '0;
   coord_type              req_pos_x = '0;
   coord_type              req_pos_y = '0;
   coord_type              req_pos_z = '0;
   logic [CONF_W-1:0]      req_confidence = '0;
   logic                   req_last_joint = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [POSE_W-1:0]      rsp_right_hand_pose;
   logic [POSE_W-1:0]      rsp_left_hand_pose;
   logic [POSE_W-1:0]      rsp_left_foot_pose;
   logic [POSE_W-1:0]      rsp_right_foot_pose;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CONF_W-1:0]      csr_conf_threshold = CONF_THRESHOLD_RESET;

   skeleton_limb_pose_classifier uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_joint_index     (req_joint_index),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_pos_z           (req_pos_z),
      .req_confidence      (req_confidence),
      .req_last_joint      (req_last_joint),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_right_hand_pose (rsp_right_hand_pose),
      .rsp_left_hand_pose  (rsp_left_hand_pose),
      .rsp_left_foot_pose  (rsp_left_foot_pose),
      .rsp_right_foot_pose (rsp_right_foot_pose),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_conf_threshold  (csr_conf_threshold)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pose predictor state
   joint_entry_type   joint_mem [NUM_JOINTS];
   logic [CONF_W-1:0] threshold = CONF_THRESHOLD_RESET;
   pose_set_type      poses = POSE_SET_RESET;

   joint_req_type joint_req_q [$];
   pose_set_type  pose_expect_q [$];
   joint_req_type offered;

   int  req_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  long_hold_req = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;
   int  error_count = 0;
   int  quiet_cycles = 0;

   function automatic longint mag(longint a, longint b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic bit passes(int j);
      return joint_mem[j].conf > int'(threshold);
   endfunction

   function automatic pose_type hand_pose(pose_type prev, int h, int s);
      joint_entry_type hj, sj, hd, nk, ts;
      hj = joint_mem[h];
      sj = joint_mem[s];
      hd = joint_mem[J_HEAD];
      nk = joint_mem[J_NECK];
      ts = joint_mem[J_TORSO];
      // tests are ordered: the first one that holds decides, even if its
      // confidences fail
      if (5 * hj.y > 5 * hd.y + mag(hd.y, nk.y))
         return (passes(h) && passes(J_HEAD)) ? POSE_UP : prev;
      if (2 * mag(hj.x, sj.x) > 3 * mag(sj.x, hd.x))
         return (passes(h) && passes(s)) ? POSE_SIDE : prev;
      if (2 * hj.z < 2 * hd.z - 3 * mag(nk.y, ts.y))
         return (passes(h) && passes(J_HEAD) && passes(J_TORSO) && passes(J_NECK)) ?
                POSE_FRONT : prev;
      if (hj.y < ts.y)
         return (passes(h) && passes(J_TORSO)) ? POSE_DOWN : prev;
      return prev;
   endfunction

   function automatic void classify_limbs();
      joint_entry_type ts, lh, lf, rh, rf;
      longint          lw, rw;
      ts = joint_mem[J_TORSO];
      lh = joint_mem[J_LHIP];
      lf = joint_mem[J_LFOOT];
      rh = joint_mem[J_RHIP];
      rf = joint_mem[J_RFOOT];
      poses.rt_hand = hand_pose(poses.rt_hand, J_RHAND, J_RSHLD);
      poses.lt_hand = hand_pose(poses.lt_hand, J_LHAND, J_LSHLD);

      lw = mag(lh.x, ts.x);
      if (2 * lf.x < 2 * lh.x - 3 * lw) begin
         if (passes(J_LFOOT) && passes(J_LHIP) && passes(J_TORSO))
            poses.lt_foot = POSE_SIDE;
      end else if (lf.z < ts.z - lw) begin
         if (passes(J_LFOOT) && passes(J_LHIP) && passes(J_TORSO))
            poses.lt_foot = POSE_FRONT;
      end else begin
         // left foot down also needs the right foot confidence
         if (passes(J_LFOOT) && passes(J_LHIP) && passes(J_TORSO) && passes(J_RFOOT))
            poses.lt_foot = POSE_DOWN;
      end

      rw = mag(rh.x, ts.x);
      if (2 * rf.x > 2 * rh.x + 3 * rw) begin
         if (passes(J_RFOOT) && passes(J_RHIP) && passes(J_TORSO))
            poses.rt_foot = POSE_SIDE;
      end else if (rf.z < ts.z - rw) begin
         // right foot front checks the left hip confidence
         if (passes(J_RFOOT) && passes(J_LHIP) && passes(J_TORSO))
            poses.rt_foot = POSE_FRONT;
      end else begin
         if (passes(J_RFOOT) && passes(J_RHIP) && passes(J_TORSO))
            poses.rt_foot = POSE_DOWN;
      end
   endfunction

   function automatic void absorb_joint(joint_req_type r);
      if (r.joint_index < NUM_JOINTS) begin
         joint_mem[r.joint_index].x    = r.pos_x;
         joint_mem[r.joint_index].y    = r.pos_y;
         joint_mem[r.joint_index].z    = r.pos_z;
         joint_mem[r.joint_index].conf = r.confidence;
      end
      if (r.last_joint) begin
         classify_limbs();
         pose_expect_q.insert(pose_expect_q.size(), poses);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            absorb_joint(offered);
         if (!req_valid || !req_stall) begin
            if (joint_req_q.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               offered = joint_req_q.pop_front();
               req_joint_index <= offered.joint_index;
               req_pos_x       <= offered.pos_x;
               req_pos_y       <= offered.pos_y;
               req_pos_z       <= offered.pos_z;
               req_confidence  <= offered.confidence;
               req_last_joint  <= offered.last_joint;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_pose(string limb, pose_type want, logic [POSE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s pose mismatch, expected %0d, actual %0d", $time, limb, want, got);
         error_count++;
      end
   endtask

   // response monitor and stall control
   always @(posedge clock) begin
      pose_set_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pose_expect_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d %0d %0d %0d",
                        $time, rsp_right_hand_pose, rsp_left_hand_pose,
                        rsp_left_foot_pose, rsp_right_foot_pose);
               error_count++;
            end else begin
               want = pose_expect_q.pop_front();
               check_pose("right hand", want.rt_hand, rsp_right_hand_pose);
               check_pose("left hand", want.lt_hand, rsp_left_hand_pose);
               check_pose("left foot", want.lt_foot, rsp_left_foot_pose);
               check_pose("right foot", want.rt_foot, rsp_right_foot_pose);
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (long_hold_req && !hold_done && rsp_valid) begin
            // hold the response long enough for the request side to back up
            rsp_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic coord_type pick_coord();
      if ($urandom_range(0, 9) == 0)
         return coord_type'($urandom);
      return coord_type'($urandom_range(0, 12000) - 6000);
   endfunction

   function automatic logic [CONF_W-1:0] pick_conf();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return threshold;
      if (roll < 8 && threshold != 8'hFF)
         return CONF_W'($urandom_range(int'(threshold) + 1, 255));
      return CONF_W'($urandom_range(0, 255));
   endfunction

   task automatic put_joint(int idx, int x, int y, int z, int conf, bit last);
      joint_req_type r;
      r.joint_index = JOINT_IDX_W'(idx);
      r.pos_x       = coord_type'(x);
      r.pos_y       = coord_type'(y);
      r.pos_z       = coord_type'(z);
      r.confidence  = CONF_W'(conf);
      r.last_joint  = last;
      joint_req_q.insert(joint_req_q.size(), r);
   endtask

   task automatic put_random(int idx, bit last);
      put_joint(idx, pick_coord(), pick_coord(), pick_coord(), pick_conf(), last);
   endtask

   // mostly whole frames; some cut-off frames and stray requests
   task automatic push_frame();
      int unsigned roll;
      int          stop_at;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         for (int j = 0; j < NUM_JOINTS; j++)
            put_random(j, j == NUM_JOINTS - 1);
      end else if (roll < 90) begin
         stop_at = $urandom_range(0, 15);
         for (int j = 0; j < stop_at; j++)
            if ($urandom_range(0, 1))
               put_random(j, 1'b0);
         put_random(stop_at, 1'b1);
      end else begin
         repeat ($urandom_range(1, 6))
            put_random($urandom_range(0, 15), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic wait_drained();
      while (joint_req_q.size() != 0 || req_valid || pose_expect_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [CONF_W-1:0] value);
      @(posedge clock);
      csr_valid          <= 1'b1;
      csr_conf_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      threshold = value;
   endtask

   task automatic run_phase(logic [CONF_W-1:0] thr, int idle_pct, int stall_pct,
                            int frames);
      wait_drained();
      write_threshold(thr);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (frames) push_frame();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full first frame so no store entry is read before it is written;
      // reset threshold 128 throughout this part
      put_joint(0, 0, 6144, 0, 200, 0);
      put_joint(1, 0, 5734, 0, 200, 0);
      put_joint(2, 0, 4096, 0, 200, 0);
      put_joint(3, -1228, 5734, 0, 200, 0);
      put_joint(4, -32768, 32767, -32768, 0, 0);
      put_joint(5, -4096, 4500, 0, 200, 0);
      put_joint(6, 1228, 5734, 0, 200, 0);
      put_joint(7, 32767, -32768, 32767, 255, 0);
      put_joint(8, 1228, 8192, 0, 200, 0);
      put_joint(9, -800, 2000, 0, 200, 0);
      put_joint(10, 0, 0, 0, 200, 0);
      put_joint(11, -4096, 0, 0, 200, 0);
      put_joint(12, 800, 2000, 0, 200, 0);
      put_joint(13, 0, 0, 0, 200, 0);
      put_joint(14, 800, 0, 0, 200, 1);
      // right hand front, then down
      put_joint(8, 1228, 0, -8192, 200, 1);
      put_joint(8, 1228, 0, 0, 200, 1);
      // left hand up at the coordinate extremes
      put_joint(5, -1228, 32767, 32767, 200, 1);
      // front test holds but confidence equal to threshold keeps the old code
      put_joint(5, -1228, 5000, -32768, 128, 1);
      put_joint(5, -1228, 5000, -32768, 129, 1);
      // left foot front, then down
      put_joint(11, -800, 0, -4096, 200, 1);
      put_joint(11, -800, 0, 0, 200, 1);
      // right foot side, then front
      put_joint(14, 8192, 0, 0, 200, 1);
      put_joint(14, 800, 0, -4096, 200, 1);
      // joint index fifteen is not stored but still classifies
      put_joint(15, -32768, -32768, -32768, 255, 1);

      run_phase(8'd0, 0, 0, 20);
      run_phase(8'd0, 76, 0, 20);
      run_phase(8'd255, 0, 76, 15);
      run_phase(8'd100, 27, 27, 20);

      // back-pressure: long response hold while requests keep coming
      long_hold_req = 1'b1;
      run_phase(CONF_THRESHOLD_RESET, 0, 0, 12);
      wait_drained();
      long_hold_req = 1'b0;
      repeat (8) push_frame();

      run_phase(CONF_W'($urandom_range(0, 255)), 0, 0, 23);

      wait_drained();
      repeat (6) @(posedge clock);
      if (error_count == 0 && pose_expect_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
